// ===== hdl/chlit_pkg.sv =====
package chlit_pkg;

  localparam int unsigned CharWidth   = 21;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned LengthWidth = 16;

  // count saturates here, equal to the field maximum
  localparam logic [LengthWidth-1:0] MaxLength = 16'hFFFF;

  localparam logic [StatusWidth-1:0] StOk     = 3'd0;
  localparam logic [StatusWidth-1:0] StNotLit = 3'd1;
  localparam logic [StatusWidth-1:0] StEmpty  = 3'd2;
  localparam logic [StatusWidth-1:0] StBadEsc = 3'd3;
  localparam logic [StatusWidth-1:0] StBadHex = 3'd4;
  localparam logic [StatusWidth-1:0] StBadEnd = 3'd5;

  localparam logic [CharWidth-1:0] ChQuote  = 21'h27;
  localparam logic [CharWidth-1:0] ChBslash = 21'h5C;
  localparam logic [CharWidth-1:0] ChDquote = 21'h22;
  localparam logic [CharWidth-1:0] ChLowerU = 21'h75;
  localparam logic [CharWidth-1:0] ChUpperU = 21'h55;
  localparam logic [CharWidth-1:0] ChLowerX = 21'h78;

  localparam logic [3:0] HexCountU = 4'd4;
  localparam logic [3:0] HexCountW = 4'd8;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [LengthWidth-1:0] token_length;
  } result_t;

  function automatic logic is_hex(input logic [CharWidth-1:0] c);
    is_hex = (c >= 21'h30 && c <= 21'h39) || (c >= 21'h61 && c <= 21'h66) ||
             (c >= 21'h41 && c <= 21'h46);
  endfunction

  function automatic logic is_simple_escape(input logic [CharWidth-1:0] c);
    is_simple_escape = c == 21'h6E || c == 21'h74 || c == 21'h76 || c == 21'h62 ||
                       c == 21'h72 || c == 21'h66 || c == 21'h61 || c == 21'h30 ||
                       c == ChBslash || c == ChQuote || c == ChDquote;
  endfunction

endpackage

// ===== hdl/chlit_in_if.sv =====
interface chlit_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] char_code;
  logic        first;
  logic        last;

  modport source (output valid, output char_code, output first, output last, input ready);
  modport sink (input valid, input char_code, input first, input last, output ready);
endinterface

// ===== hdl/chlit_out_if.sv =====
interface chlit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] token_length;

  modport source (output valid, output status, output token_length, input ready);
  modport sink (input valid, input status, input token_length, output ready);
endinterface

// ===== hdl/char_literal_recognizer.sv =====
// each verdict is registered in the output register, or in the skid entry on a stall
// one character per cycle while the skid entry is empty; scan state registers on accept
// a two-entry output buffer lets input continue while one verdict waits to be taken
// reset (asynchronous, active low) leaves the scanner idle with no verdict pending;
// non-first characters are ignored until a first-marked character arrives
module char_literal_recognizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  chlit_in_if.sink          in_i,
  chlit_out_if.source       out_o
);
  import chlit_pkg::*;

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhOpen   = 3'd1;
  localparam logic [2:0] PhPlain  = 3'd2;
  localparam logic [2:0] PhEsc    = 3'd3;
  localparam logic [2:0] PhFix    = 3'd4;
  localparam logic [2:0] PhFixBad = 3'd5;
  localparam logic [2:0] PhXhex   = 3'd6;
  localparam logic [2:0] PhSimple = 3'd7;

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             hex_q, hex_d;
  logic [LengthWidth-1:0] cnt_q, cnt_d, cnt_inc;

  logic                   res_valid;
  logic [StatusWidth-1:0] res_status;
  result_t                res_new;

  logic                   out_valid_q, skid_valid_q;
  result_t                out_q, skid_q;

  logic                   accept, push, pop;
  logic [CharWidth-1:0]   c;

  assign c       = in_i.char_code;
  assign cnt_inc = (cnt_q < MaxLength) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    phase_d    = phase_q;
    hex_d      = hex_q;
    cnt_d      = cnt_q;
    res_valid  = 1'b0;
    res_status = StOk;
    if (in_i.first) begin
      cnt_d = {{(LengthWidth-1){1'b0}}, 1'b1};
      hex_d = '0;
      if (c != ChQuote || in_i.last) begin
        res_valid  = 1'b1;
        res_status = StNotLit;
      end else begin
        phase_d = PhOpen;
      end
    end else if (phase_q != PhIdle) begin
      cnt_d = cnt_inc;
      case (phase_q)
        PhOpen: begin
          if (in_i.last) begin
            res_valid  = 1'b1;
            res_status = StNotLit;
          end else if (c == ChQuote) begin
            res_valid  = 1'b1;
            res_status = StEmpty;
          end else begin
            phase_d = (c == ChBslash) ? PhEsc : PhPlain;
          end
        end
        PhPlain, PhSimple: begin
          res_valid  = 1'b1;
          res_status = (c == ChQuote) ? StOk : StBadEnd;
        end
        PhEsc: begin
          if (c == ChLowerU || c == ChUpperU || c == ChLowerX || is_simple_escape(c)) begin
            if (in_i.last) begin
              res_valid  = 1'b1;
              res_status = StBadEnd;
            end else if (c == ChLowerU || c == ChUpperU) begin
              hex_d   = (c == ChLowerU) ? HexCountU : HexCountW;
              phase_d = PhFix;
            end else if (c == ChLowerX) begin
              phase_d = PhXhex;
            end else begin
              phase_d = PhSimple;
            end
          end else begin
            res_valid  = 1'b1;
            res_status = StBadEsc;
          end
        end
        PhFix, PhFixBad: begin
          if (hex_q != '0) begin
            if (in_i.last) begin
              res_valid  = 1'b1;
              res_status = StBadEnd;
            end else begin
              if (!is_hex(c)) phase_d = PhFixBad;
              hex_d = hex_q - 1'b1;
            end
          end else if (phase_q == PhFixBad) begin
            res_valid  = 1'b1;
            res_status = StBadHex;
          end else begin
            res_valid  = 1'b1;
            res_status = (c == ChQuote) ? StOk : StBadEnd;
          end
        end
        PhXhex: begin
          if (c == ChQuote) begin
            res_valid  = 1'b1;
            res_status = StOk;
          end else if (!is_hex(c)) begin
            res_valid  = 1'b1;
            res_status = StBadHex;
          end else if (in_i.last) begin
            res_valid  = 1'b1;
            res_status = StBadEnd;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
    // every verdict closes the scan
    if (res_valid) begin
      phase_d = PhIdle;
      hex_d   = '0;
    end
    res_new.status       = res_status;
    res_new.token_length = (res_status == StOk) ? cnt_d : '0;
  end

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && res_valid;
  assign pop        = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hex_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= push;
      end else if (push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if ((pop || !out_valid_q) && push) begin
      out_q <= res_new;
    end
    // skid only fills while the output register holds a stalled verdict
    if (!pop && out_valid_q && push) begin
      skid_q <= res_new;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.token_length = out_q.token_length;

  a_len_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != StOk |-> out_o.token_length == '0)
    else $error("nonzero token length on a rejected literal");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_hex_in_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_q != '0 |-> (phase_q == PhFix || phase_q == PhFixBad))
    else $error("hex digits pending outside a fixed-width escape");

  a_verdict_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> phase_q == PhIdle && hex_q == '0)
    else $error("scanner not idle after a verdict");

endmodule

// ===== tb/tb_char_literal_recognizer.sv =====
module tb_char_literal_recognizer;
  timeunit 1ns;
  timeprecision 1ps;

  import chlit_pkg::*;

  typedef logic [CharWidth-1:0] chr_t;

  typedef enum logic [2:0] {
    PhIdle, PhOpen, PhPlain, PhEscape, PhFixHex, PhFixBad, PhXHex, PhSimple
  } lit_phase_e;

  localparam int unsigned RandomItems = 1800;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam chr_t        MaxCodePoint = 21'h10FFFF;

  // works out the verdict of each scan as characters are accepted
  class verdict_predictor;
    lit_phase_e             phase;
    logic [3:0]             hex_left;
    logic [LengthWidth-1:0] count;
    result_t                pending[$];
    int unsigned            mismatches;

    function new();
      phase      = PhIdle;
      hex_left   = '0;
      count      = '0;
      mismatches = 0;
    endfunction

    function bit hex_digit(chr_t c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit simple_escape(chr_t c);
      return c == "n" || c == "t" || c == "v" || c == "b" || c == "r" || c == "f" ||
             c == "a" || c == "0" || c == ChBslash || c == ChQuote || c == ChDquote;
    endfunction

    function void give(logic [StatusWidth-1:0] st);
      result_t r;
      r.status       = st;
      r.token_length = (st == StOk) ? count : '0;
      pending.push_back(r);
      phase    = PhIdle;
      hex_left = '0;
    endfunction

    function void note_char(chr_t c, logic fst, logic lst);
      if (fst) begin
        count    = LengthWidth'(1);
        hex_left = '0;
        if (c != ChQuote || lst) give(StNotLit);
        else phase = PhOpen;
        return;
      end
      if (phase == PhIdle) return;
      if (count < MaxLength) count++;
      case (phase)
        PhOpen: begin
          if (lst) give(StNotLit);
          else if (c == ChQuote) give(StEmpty);
          else phase = (c == ChBslash) ? PhEscape : PhPlain;
        end
        PhPlain, PhSimple: give(c == ChQuote ? StOk : StBadEnd);
        PhEscape: begin
          if (c == ChLowerU || c == ChUpperU || c == ChLowerX || simple_escape(c)) begin
            if (lst) give(StBadEnd);
            else if (c == ChLowerX) phase = PhXHex;
            else if (c == ChLowerU) begin
              hex_left = HexCountU;
              phase    = PhFixHex;
            end else if (c == ChUpperU) begin
              hex_left = HexCountW;
              phase    = PhFixHex;
            end else phase = PhSimple;
          end else give(StBadEsc);
        end
        PhFixHex, PhFixBad: begin
          if (hex_left != 0) begin
            // a bad digit only shows once the closing position is reached
            if (lst) give(StBadEnd);
            else begin
              if (!hex_digit(c)) phase = PhFixBad;
              hex_left--;
            end
          end else if (phase == PhFixBad) give(StBadHex);
          else give(c == ChQuote ? StOk : StBadEnd);
        end
        PhXHex: begin
          if (c == ChQuote) give(StOk);
          else if (!hex_digit(c)) give(StBadHex);
          else if (lst) give(StBadEnd);
        end
        default: phase = PhIdle;
      endcase
    endfunction

    function void check_verdict(logic [StatusWidth-1:0] st, logic [LengthWidth-1:0] len);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: verdict with none expected: status %0d length %0d", $time, st, len);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, st);
        mismatches++;
      end
      if (len !== want.token_length) begin
        $display("%0t: token_length mismatch: expected %0d, actual %0d",
                 $time, want.token_length, len);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;
  int unsigned sent;

  chlit_in_if  in_bus ();
  chlit_out_if out_bus ();

  verdict_predictor predictor = new();

  char_literal_recognizer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic chr_t hex_char();
    string pool;
    pool = "0123456789abcdefABCDEF";
    return chr_t'(pool[$urandom_range(0, pool.len() - 1)]);
  endfunction

  function automatic chr_t any_char();
    string pool;
    int unsigned r;
    pool = "'\\uUx\"ntvbrfa0qzG ";
    r = $urandom_range(0, 99);
    if (r < 35) return hex_char();
    if (r < 65) return chr_t'(pool[$urandom_range(0, pool.len() - 1)]);
    if (r < 80) return chr_t'($urandom_range(8'h20, 8'h7E));
    return chr_t'($urandom_range(0, MaxCodePoint));
  endfunction

  function automatic chr_t escape_char();
    string pool;
    pool = "ntvbrfa0\\'\"";
    if ($urandom_range(0, 99) < 85) return chr_t'(pool[$urandom_range(0, pool.len() - 1)]);
    return any_char();
  endfunction

  task automatic put_char(input chr_t c, input logic fst, input logic lst, input bit gaps_on);
    int unsigned gap;
    in_bus.valid     <= 1'b1;
    in_bus.char_code <= c;
    in_bus.first     <= fst;
    in_bus.last      <= lst;
    do @(posedge clk); while (!in_bus.ready);
    predictor.note_char(c, fst, lst);
    sent++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input chr_t text[$], input int last_at, input bit gaps_on);
    foreach (text[i]) put_char(text[i], i == 0, i == last_at, gaps_on);
  endtask

  // mostly well-formed literals with random content, plus damaged and cut-off ones
  task automatic build_text(output chr_t text[$], output int last_at);
    int unsigned kind;
    int unsigned r;
    text = '{ChQuote};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: text.push_back(any_char());
      2, 3: begin
        text.push_back(ChBslash);
        text.push_back(escape_char());
      end
      4, 5: begin
        text.push_back(ChBslash);
        text.push_back(kind == 4 ? ChLowerU : ChUpperU);
        repeat (kind == 4 ? HexCountU : HexCountW)
          text.push_back($urandom_range(0, 99) < 8 ? any_char() : hex_char());
      end
      6, 7: begin
        text.push_back(ChBslash);
        text.push_back(ChLowerX);
        repeat ($urandom_range(0, 6)) text.push_back(hex_char());
      end
      8: begin
        text.push_back(ChBslash);
        text.push_back(any_char());
      end
      default: begin
        if ($urandom_range(0, 1)) text[0] = any_char();
        repeat ($urandom_range(0, 5)) text.push_back(any_char());
      end
    endcase
    if (kind < 9) text.push_back(ChQuote);
    if (text.size() > 1 && $urandom_range(0, 4) == 0)
      text[$urandom_range(1, text.size() - 1)] = any_char();
    last_at = -1;
    r = $urandom_range(0, 99);
    if (r < 30) last_at = text.size() - 1;
    else if (r < 50) begin
      last_at = $urandom_range(0, text.size() - 1);
      text = text[0:last_at];
    end else if (r < 60) begin
      // left unfinished: the next first-marked character abandons it
      text = text[0:$urandom_range(0, text.size() - 1)];
    end else if (r < 70) begin
      repeat ($urandom_range(1, 2)) text.push_back(any_char());
      if ($urandom_range(0, 1)) last_at = text.size() - 1;
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      begin
        int unsigned stall;
        stall = pick_gap();
        if (stall != 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      predictor.check_verdict(out_bus.status, out_bus.token_length);
  end

  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_n);
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    chr_t text[$];
    int   last_at;
    int unsigned stop_at;
    in_bus.valid     = 1'b0;
    in_bus.char_code = '0;
    in_bus.first     = 1'b0;
    in_bus.last      = 1'b0;
    hold_req         = 1'b0;
    sent             = 0;
    rst_n            = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain, empty, short, escapes, x hex cases, abandoned scan, idle char
    send_text('{ChQuote}, -1, 1'b1);
    send_text('{ChQuote, chr_t'("a"), ChQuote}, 2, 1'b1);
    send_text('{ChQuote, ChQuote}, -1, 1'b0);
    put_char(chr_t'("a"), 1'b0, 1'b0, 1'b1);
    send_text('{ChQuote}, 0, 1'b1);
    send_text('{MaxCodePoint}, -1, 1'b0);
    send_text('{ChQuote, ChBslash, chr_t'("q")}, -1, 1'b1);
    send_text('{ChQuote, ChBslash, ChLowerX, ChQuote}, 3, 1'b0);
    send_text('{ChQuote, ChBslash, ChLowerX, chr_t'("Z")}, -1, 1'b1);
    send_text('{ChQuote, ChBslash, ChLowerU, chr_t'("1")}, 3, 1'b1);

    hold_req = 1'b1;
    stop_at = sent + RandomItems;
    while (sent < stop_at) begin
      build_text(text, last_at);
      send_text(text, last_at, $urandom_range(0, 3) != 0);
    end

    in_bus.valid <= 1'b0;
    while (predictor.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (predictor.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
